// File: rtl/core/psf_pkg.sv
// psf_pkg: shared types and constants for the patterned span fill block
// no dependencies; used by psf_cfg, psf_ctrl, psf_dp and the top level
package psf_pkg;

	localparam int XW               = 10;
	localparam int GW               = 6;
	localparam int RW               = 5;
	localparam int BW               = $clog2(XW);
	localparam int SCREEN_WIDTH     = 1024;
	localparam int PATTERN_MAX_ROWS = 16;

	localparam logic [2:0] REG_PAT0   = 3'd0;
	localparam logic [2:0] REG_PAT1   = 3'd1;
	localparam logic [2:0] REG_PAT2   = 3'd2;
	localparam logic [2:0] REG_PAT3   = 3'd3;
	localparam logic [2:0] REG_BASE   = 3'd4;
	localparam logic [2:0] REG_PITCH  = 3'd5;
	localparam logic [2:0] REG_COLORS = 3'd6;
	localparam logic [2:0] REG_SETUP  = 3'd7;

	localparam logic [1:0] MODE_REPLACE = 2'd0;
	localparam logic [1:0] MODE_TRANSP  = 2'd1;
	localparam logic [1:0] MODE_XOR     = 2'd2;
	localparam logic [1:0] MODE_ERASE   = 2'd3;

	localparam logic [1:0] STYLE_HOLLOW = 2'd0;
	localparam logic [1:0] STYLE_SOLID  = 2'd1;

	localparam logic [15:0] PITCH_RST  = 16'd1024;
	localparam logic [15:0] COLORS_RST = 16'hFF00;
	localparam logic [8:0]  SETUP_RST  = 9'd20;

	typedef struct packed {
		logic [3:0][63:0] pattern;
		logic [31:0]      frame_base;
		logic [15:0]      line_pitch;
		logic [15:0]      fill_colors;
		logic [8:0]       draw_setup;
	} cfg_t;

	typedef struct packed {
		logic          load;
		logic          mod_step;
		logic [BW-1:0] mod_bit;
		logic          emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_group;
	} sts_t;

endpackage

// File: rtl/core/pattern_span_fill_8bpp_top.sv
// Patterned span fill for an 8-bit chunky framebuffer with a 16x16 pattern.
// One span is taken when in_valid is high and in_stall low; it then yields one
// write-or-invert command per 16-pixel aligned group, left to right, on the out
// channel. A span is loaded and row * line_pitch formed first, then the bit-serial
// unit finds row mod pattern height, then groups go out one per cycle while the
// output is not stalled (up to 64 for a 1024-pixel line). A reversed span counts
// as one group. in_stall stays high until the last group is in the output
// register, so the next span is taken while that command still waits. The user must
// write registers through cfg_we/cfg_index/cfg_data only while no span is in
// progress; the block itself does not enforce this.
module pattern_span_fill_8bpp_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [63:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [psf_pkg::XW-1:0]    row,
	input  logic [psf_pkg::XW-1:0]    x_start,
	input  logic [psf_pkg::XW-1:0]    x_end,
	input  logic                      last_span,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [31:0]               group_address,
	output logic [63:0]               pixels_low,
	output logic [63:0]               pixels_high,
	output logic [15:0]               byte_enables,
	output logic                      operation,
	output logic                      span_done,
	output logic                      batch_end
);

	psf_pkg::cfg_t cfg;
	psf_pkg::cmd_t cmd;
	psf_pkg::sts_t sts;

	psf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	psf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.row           (row),
		.x_start       (x_start),
		.x_end         (x_end),
		.last_span     (last_span),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.group_address (group_address),
		.pixels_low    (pixels_low),
		.pixels_high   (pixels_high),
		.byte_enables  (byte_enables),
		.operation     (operation),
		.span_done     (span_done),
		.batch_end     (batch_end)
	);

endmodule

// File: rtl/core/psf_cfg.sv
// psf_cfg: configuration register file of the patterned span fill block
// depends on psf_pkg
module psf_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output psf_pkg::cfg_t      cfg
);

	psf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern     <= '0;
			cfg_q.frame_base  <= '0;
			cfg_q.line_pitch  <= psf_pkg::PITCH_RST;
			cfg_q.fill_colors <= psf_pkg::COLORS_RST;
			cfg_q.draw_setup  <= psf_pkg::SETUP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psf_pkg::REG_PAT0:   cfg_q.pattern[0]  <= cfg_data;
				psf_pkg::REG_PAT1:   cfg_q.pattern[1]  <= cfg_data;
				psf_pkg::REG_PAT2:   cfg_q.pattern[2]  <= cfg_data;
				psf_pkg::REG_PAT3:   cfg_q.pattern[3]  <= cfg_data;
				psf_pkg::REG_BASE:   cfg_q.frame_base  <= cfg_data[31:0];
				psf_pkg::REG_PITCH:  cfg_q.line_pitch  <= cfg_data[15:0];
				psf_pkg::REG_COLORS: cfg_q.fill_colors <= cfg_data[15:0];
				psf_pkg::REG_SETUP:  cfg_q.draw_setup  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/psf_ctrl.sv
// psf_ctrl: sequencer for span load, pattern row remainder and group emission
// depends on psf_pkg; drives psf_dp through cmd_t, reads sts_t
module psf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  psf_pkg::sts_t   sts,
	output psf_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]              state_q;
	logic [psf_pkg::BW-1:0]  bit_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.mod_step = (state_q == ST_MOD);
		cmd.mod_bit  = bit_q;
		cmd.emit     = (state_q == ST_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MOD;
						bit_q   <= psf_pkg::BW'(psf_pkg::XW - 1);
					end
				end
				ST_MOD: begin
					if (bit_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (sts.out_free && sts.last_group) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_load_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_MOD))
		else $error("load not followed by remainder phase");
`endif

endmodule

// File: rtl/core/psf_dp.sv
// psf_dp: span datapath with bit-serial row remainder, line address and group builder
// depends on psf_pkg; commanded by psf_ctrl, configured from psf_cfg
module psf_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  psf_pkg::cfg_t             cfg,
	input  psf_pkg::cmd_t             cmd,
	output psf_pkg::sts_t             sts,
	input  logic [psf_pkg::XW-1:0]    row,
	input  logic [psf_pkg::XW-1:0]    x_start,
	input  logic [psf_pkg::XW-1:0]    x_end,
	input  logic                      last_span,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [31:0]               group_address,
	output logic [63:0]               pixels_low,
	output logic [63:0]               pixels_high,
	output logic [15:0]               byte_enables,
	output logic                      operation,
	output logic                      span_done,
	output logic                      batch_end
);

	localparam int XW = psf_pkg::XW;
	localparam int GW = psf_pkg::GW;
	localparam int RW = psf_pkg::RW;
	localparam logic [XW:0]   SW_LIM  = (XW+1)'(psf_pkg::SCREEN_WIDTH);
	localparam logic [XW-1:0] X_MAX   = XW'(psf_pkg::SCREEN_WIDTH - 1);
	localparam logic [RW-1:0] H_MAX   = RW'(psf_pkg::PATTERN_MAX_ROWS);

	logic [XW-1:0]    row_q, xs_q, xe_q;
	logic             last_q, rev_q;
	logic [XW+15:0]   prod_q;
	logic [31:0]      line_q;
	logic [RW-1:0]    rem_q;
	logic [GW-1:0]    g_q;

	logic             out_valid_q;
	logic [31:0]      addr_q;
	logic [63:0]      lo_q, hi_q;
	logic [15:0]      be_q;
	logic             op_q, done_q, bend_q;

	logic [XW-1:0]    xe_clip;
	logic [RW-1:0]    h_raw, h_eff, rem_sh, rem_nx;
	logic [1:0]       mode, style;
	logic [7:0]       fg, bg;
	logic [15:0]      pat_row, bits, lo_m, hi_m, be;
	logic [127:0]     data;
	logic             op, first_g, last_g;

	assign xe_clip = ({1'b0, x_end} >= SW_LIM) ? X_MAX : x_end;

	assign h_raw = cfg.draw_setup[8:4];
	always_comb begin
		priority if (h_raw == '0) begin
			h_eff = RW'(1);
		end else if (h_raw > H_MAX) begin
			h_eff = H_MAX;
		end else begin
			h_eff = h_raw;
		end
	end

	// one quotient bit per cycle, msb first
	assign rem_sh = {rem_q[RW-2:0], row_q[cmd.mod_bit]};
	assign rem_nx = (rem_sh >= h_eff) ? (rem_sh - h_eff) : rem_sh;

	assign pat_row = cfg.pattern[rem_q[3:2]][{rem_q[1:0], 4'b0000} +: 16];

	always_comb begin
		style = cfg.draw_setup[3:2];
		mode  = cfg.draw_setup[1:0];
		fg    = cfg.fill_colors[15:8];
		bg    = cfg.fill_colors[7:0];
		bits  = pat_row;
		if (style == psf_pkg::STYLE_HOLLOW) begin
			bits = '0;
			fg   = '0;
			bg   = '0;
			mode = psf_pkg::MODE_REPLACE;
		end else if (style == psf_pkg::STYLE_SOLID) begin
			bits = 16'hFFFF;
		end
	end

	assign op      = (mode == psf_pkg::MODE_XOR) || (mode == psf_pkg::MODE_ERASE);
	assign first_g = (g_q == xs_q[XW-1:4]);
	assign last_g  = (g_q == xe_q[XW-1:4]);
	assign lo_m    = first_g ? (16'hFFFF << xs_q[3:0]) : 16'hFFFF;
	assign hi_m    = last_g ? (16'hFFFF >> (4'd15 - xe_q[3:0])) : 16'hFFFF;

	always_comb begin
		logic set_b;
		logic en_b;
		be   = '0;
		data = '0;
		for (int p = 0; p < 16; p++) begin
			set_b = bits[15 - p];
			unique case (mode)
				psf_pkg::MODE_REPLACE: en_b = 1'b1;
				psf_pkg::MODE_TRANSP:  en_b = set_b;
				psf_pkg::MODE_XOR:     en_b = 1'b1;
				psf_pkg::MODE_ERASE:   en_b = !set_b;
				default:               en_b = 1'b0;
			endcase
			be[p] = lo_m[p] && hi_m[p] && en_b && !rev_q;
			if (be[p] && !op) begin
				data[8*p +: 8] = set_b ? fg : bg;
			end
		end
	end

	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.last_group = rev_q || last_g;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q  <= row;
			xs_q   <= x_start;
			xe_q   <= xe_clip;
			last_q <= last_span;
			rev_q  <= (x_start > xe_clip);
			prod_q <= (XW+16)'(row) * (XW+16)'(cfg.line_pitch);
			rem_q  <= '0;
			g_q    <= x_start[XW-1:4];
		end
		if (cmd.mod_step) begin
			rem_q  <= rem_nx;
			line_q <= cfg.frame_base + 32'(prod_q);
		end
		if (cmd.emit) begin
			addr_q <= line_q + {{(32-GW-4){1'b0}}, g_q, 4'b0000};
			lo_q   <= data[63:0];
			hi_q   <= data[127:64];
			be_q   <= be;
			op_q   <= op && !rev_q;
			done_q <= sts.last_group;
			bend_q <= sts.last_group && last_q;
			g_q    <= g_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign group_address = addr_q;
	assign pixels_low    = lo_q;
	assign pixels_high   = hi_q;
	assign byte_enables  = be_q;
	assign operation     = op_q;
	assign span_done     = done_q;
	assign batch_end     = bend_q;

`ifndef SYNTHESIS
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("group emitted over a held item");
	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (rem_q < h_eff))
		else $error("pattern row remainder out of range");
	a_batch_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!bend_q || done_q))
		else $error("batch end without span done");
`endif

endmodule

// File: sim/pattern_span_fill_8bpp_checker.sv
`timescale 1ns / 1ps
// pattern_span_fill_8bpp_checker: watches the register port and both item channels,
// expands every accepted span into its group commands and compares them in order
// depends on psf_pkg for register indexes, write modes, styles and screen limits
module pattern_span_fill_8bpp_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [63:0]            cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [psf_pkg::XW-1:0] row,
	input  logic [psf_pkg::XW-1:0] x_start,
	input  logic [psf_pkg::XW-1:0] x_end,
	input  logic                   last_span,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [31:0]            group_address,
	input  logic [63:0]            pixels_low,
	input  logic [63:0]            pixels_high,
	input  logic [15:0]            byte_enables,
	input  logic                   operation,
	input  logic                   span_done,
	input  logic                   batch_end,
	output int                     errors,
	output int                     pending,
	output int                     spans_seen,
	output int                     groups_checked
);

	typedef struct packed {
		logic [31:0] address;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] enables;
		logic        invert;
		logic        done;
		logic        batch_last;
	} group_cmd_t;

	logic [3:0][63:0] pat_q;
	logic [31:0]      base_q;
	logic [15:0]      pitch_q;
	logic [15:0]      colors_q;
	logic [8:0]       setup_q;
	group_cmd_t       expected_cmds [$];

	initial begin
		errors = 0;
		pending = 0;
		spans_seen = 0;
		groups_checked = 0;
	end

	function automatic void span_to_groups(input logic [9:0] y, input logic [9:0] xs,
			input logic [9:0] xe_in, input logic last);
		logic [1:0]   mode;
		logic [1:0]   style;
		logic [4:0]   height;
		logic [7:0]   fg;
		logic [7:0]   bg;
		logic [15:0]  bits;
		logic [3:0]   prow;
		logic [9:0]   xe;
		logic [31:0]  line_addr;
		logic [127:0] data;
		logic         inv;
		logic         hit;
		logic         en;
		int           g;
		int           p;
		int           p_lo;
		int           p_hi;
		group_cmd_t   c;

		mode = setup_q[1:0];
		style = setup_q[3:2];
		height = setup_q[8:4];
		fg = colors_q[15:8];
		bg = colors_q[7:0];
		if (height == 0)
			height = 1;
		if (height > psf_pkg::PATTERN_MAX_ROWS)
			height = psf_pkg::PATTERN_MAX_ROWS;

		if (style == psf_pkg::STYLE_HOLLOW) begin
			bits = '0;
			fg = '0;
			bg = '0;
			mode = psf_pkg::MODE_REPLACE;
		end else if (style == psf_pkg::STYLE_SOLID) begin
			bits = 16'hFFFF;
		end else begin
			prow = 4'(y % height);
			bits = 16'(pat_q[prow[3:2]] >> {prow[1:0], 4'b0000});
		end
		inv = (mode == psf_pkg::MODE_XOR) || (mode == psf_pkg::MODE_ERASE);
		line_addr = base_q + 32'(y) * 32'(pitch_q);

		xe = xe_in;
		if (xe >= psf_pkg::SCREEN_WIDTH)
			xe = 10'(psf_pkg::SCREEN_WIDTH - 1);

		// reversed span: one empty command at the group of x_start
		if (xs > xe) begin
			c = '0;
			c.address = line_addr + {22'b0, xs[9:4], 4'b0000};
			c.done = 1'b1;
			c.batch_last = last;
			expected_cmds.push_back(c);
			return;
		end

		for (g = int'(xs[9:4]); g <= int'(xe[9:4]); g++) begin
			p_lo = (g == int'(xs[9:4])) ? int'(xs[3:0]) : 0;
			p_hi = (g == int'(xe[9:4])) ? int'(xe[3:0]) : 15;
			c = '0;
			data = '0;
			for (p = p_lo; p <= p_hi; p++) begin
				hit = bits[15 - p];
				case (mode)
					psf_pkg::MODE_REPLACE: en = 1'b1;
					psf_pkg::MODE_TRANSP:  en = hit;
					psf_pkg::MODE_XOR:     en = 1'b1;
					default:               en = !hit;
				endcase
				if (en) begin
					c.enables[p] = 1'b1;
					if (!inv)
						data[8*p +: 8] = hit ? fg : bg;
				end
			end
			c.address = line_addr + (32'(g) << 4);
			c.lo = data[63:0];
			c.hi = data[127:64];
			c.invert = inv;
			c.done = (g == int'(xe[9:4]));
			c.batch_last = c.done && last;
			expected_cmds.push_back(c);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		group_cmd_t seen;
		group_cmd_t want;

		if (!arst_n) begin
			pat_q <= '0;
			base_q <= '0;
			pitch_q <= psf_pkg::PITCH_RST;
			colors_q <= psf_pkg::COLORS_RST;
			setup_q <= psf_pkg::SETUP_RST;
			expected_cmds.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					psf_pkg::REG_PAT0, psf_pkg::REG_PAT1, psf_pkg::REG_PAT2,
					psf_pkg::REG_PAT3:   pat_q[cfg_index[1:0]] <= cfg_data;
					psf_pkg::REG_BASE:   base_q <= cfg_data[31:0];
					psf_pkg::REG_PITCH:  pitch_q <= cfg_data[15:0];
					psf_pkg::REG_COLORS: colors_q <= cfg_data[15:0];
					psf_pkg::REG_SETUP:  setup_q <= cfg_data[8:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				seen = '{group_address, pixels_low, pixels_high, byte_enables,
					operation, span_done, batch_end};
				groups_checked++;
				if (expected_cmds.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected group command at %0t: addr %h", $realtime,
							seen.address);
				end else begin
					want = expected_cmds.pop_front();
					if (seen !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("group command mismatch at %0t", $realtime);
							$display("  expected addr %h lo %h hi %h be %h op %b done %b end %b",
								want.address, want.lo, want.hi, want.enables, want.invert,
								want.done, want.batch_last);
							$display("  actual   addr %h lo %h hi %h be %h op %b done %b end %b",
								seen.address, seen.lo, seen.hi, seen.enables, seen.invert,
								seen.done, seen.batch_last);
						end
					end
				end
			end

			if (in_valid && !in_stall) begin
				spans_seen++;
				span_to_groups(row, x_start, x_end, last_span);
			end

			pending <= expected_cmds.size();
		end
	end

endmodule

// File: sim/tb_pattern_span_fill_8bpp_top.sv
`timescale 1ns / 1ps
// tb_pattern_span_fill_8bpp_top: drives spans and register settings into the span fill
// block with random idling on both channels; checking is done by the checker module
module tb_pattern_span_fill_8bpp_top;

	localparam logic [1:0] STYLE_PATTERN     = 2'd2;
	localparam logic [1:0] STYLE_PATTERN_ALT = 2'd3;
	localparam int         SETTLE_CYCLES     = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [9:0]  row = '0;
	logic [9:0]  x_start = '0;
	logic [9:0]  x_end = '0;
	logic        last_span = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] group_address;
	logic [63:0] pixels_low;
	logic [63:0] pixels_high;
	logic [15:0] byte_enables;
	logic        operation;
	logic        span_done;
	logic        batch_end;

	int errors;
	int pending;
	int spans_seen;
	int groups_checked;

	int send_gap_pct = 6;
	int stall_pct = 49;
	int config_loads = 0;

	logic [3:0][63:0] cfg_pat;
	logic [31:0]      cfg_base;
	logic [15:0]      cfg_pitch;
	logic [15:0]      cfg_colors;
	logic [8:0]       cfg_setup;

	logic [1:0] all_modes [4] = '{psf_pkg::MODE_REPLACE, psf_pkg::MODE_TRANSP,
		psf_pkg::MODE_XOR, psf_pkg::MODE_ERASE};

	pattern_span_fill_8bpp_top dut (.*);

	pattern_span_fill_8bpp_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config();
		write_reg(psf_pkg::REG_PAT0, cfg_pat[0]);
		write_reg(psf_pkg::REG_PAT1, cfg_pat[1]);
		write_reg(psf_pkg::REG_PAT2, cfg_pat[2]);
		write_reg(psf_pkg::REG_PAT3, cfg_pat[3]);
		write_reg(psf_pkg::REG_BASE, 64'(cfg_base));
		write_reg(psf_pkg::REG_PITCH, 64'(cfg_pitch));
		write_reg(psf_pkg::REG_COLORS, 64'(cfg_colors));
		write_reg(psf_pkg::REG_SETUP, 64'(cfg_setup));
		config_loads++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic send_span(input logic [9:0] y, input logic [9:0] xs, input logic [9:0] xe,
			input logic last);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		row <= y;
		x_start <= xs;
		x_end <= xe;
		last_span <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_span();
		logic [9:0] y;
		logic [9:0] xs;
		logic [9:0] xe;
		int         kind;
		int         len;

		y = 10'($urandom);
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			xs = 10'($urandom_range(1, 1023));
			xe = 10'($urandom_range(0, xs - 1));
		end else if (kind < 20) begin
			xs = 10'($urandom_range(0, 31));
			xe = 10'($urandom_range(992, 1023));
		end else begin
			xs = 10'($urandom);
			len = $urandom_range(0, 63);
			xe = (int'(xs) + len > 1023) ? 10'd1023 : 10'(int'(xs) + len);
		end
		send_span(y, xs, xe, $urandom_range(0, 3) == 0);
	endtask

	task automatic run_random(input int count);
		logic [31:0] addr;

		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				wait_idle();
				for (int r = 0; r < 4; r++)
					cfg_pat[r] = {$urandom, $urandom};
				addr = $urandom;
				case ($urandom_range(0, 7))
					0: cfg_base = '0;
					1: cfg_base = '1;
					2: cfg_base = addr;
					default: cfg_base = {addr[31:4], 4'b0000};
				endcase
				case ($urandom_range(0, 7))
					0: cfg_pitch = '0;
					1: cfg_pitch = '1;
					default: cfg_pitch = 16'($urandom);
				endcase
				cfg_colors = 16'($urandom);
				cfg_setup = 9'($urandom);
				load_config();
			end
			send_random_span();
		end
	endtask

	initial begin
		#5_000_000;
		$display("tb_pattern_span_fill_8bpp_top NOT OK");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: solid replace, white on black
		send_span(10'd0, 10'd0, 10'd1023, 1'b1);
		send_span(10'd1023, 10'd15, 10'd16, 1'b0);
		send_span(10'd512, 10'd1023, 10'd0, 1'b1);
		send_span(10'd7, 10'd9, 10'd9, 1'b0);

		// all ones everywhere: address wrap, saturated height, erase with no enables
		wait_idle();
		cfg_pat = '1;
		cfg_base = '1;
		cfg_pitch = '1;
		cfg_colors = '1;
		cfg_setup = '1;
		load_config();
		send_span(10'd1023, 10'd0, 10'd1023, 1'b1);

		// all zeros: hollow style, zero height, zero pitch
		wait_idle();
		cfg_pat = '0;
		cfg_base = '0;
		cfg_pitch = '0;
		cfg_colors = '0;
		cfg_setup = '0;
		load_config();
		send_span(10'd1023, 10'd1000, 10'd1023, 1'b0);

		wait_idle();
		cfg_pat[0] = 64'h8001_F00F_AAAA_5555;
		cfg_pat[1] = 64'h0000_FFFF_1234_8000;
		cfg_pat[2] = {$urandom, $urandom};
		cfg_pat[3] = {$urandom, $urandom};
		cfg_base = 32'h0001_0000;
		cfg_pitch = 16'd640;
		cfg_colors = 16'hA55A;
		cfg_setup = {5'd5, STYLE_PATTERN, psf_pkg::MODE_REPLACE};
		load_config();
		foreach (all_modes[m]) begin
			wait_idle();
			write_reg(psf_pkg::REG_SETUP, 64'({5'd5, STYLE_PATTERN, all_modes[m]}));
			send_span(10'(2 * m), 10'd3, 10'd70, 1'b0);
			send_span(10'(2 * m + 1), 10'd17, 10'd31, 1'b1);
		end
		wait_idle();
		write_reg(psf_pkg::REG_SETUP,
			64'({5'd1, psf_pkg::STYLE_SOLID, psf_pkg::MODE_ERASE}));
		send_span(10'd3, 10'd5, 10'd40, 1'b1);
		wait_idle();
		write_reg(psf_pkg::REG_SETUP,
			64'({5'd1, psf_pkg::STYLE_HOLLOW, psf_pkg::MODE_XOR}));
		send_span(10'd4, 10'd0, 10'd47, 1'b0);
		wait_idle();
		write_reg(psf_pkg::REG_SETUP,
			64'({5'd16, STYLE_PATTERN_ALT, psf_pkg::MODE_TRANSP}));
		send_span(10'd15, 10'd100, 10'd300, 1'b1);

		run_random(150);
		wait_idle();
		send_gap_pct <= 49;
		stall_pct <= 6;
		run_random(150);
		wait_idle();
		send_gap_pct <= 0;
		stall_pct <= 0;
		run_random(160);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d spans and %0d group commands checked over %0d full register loads",
			spans_seen, groups_checked, config_loads);
		$display("all four write modes, three styles, reversed spans and three idling mixes");
		if (errors == 0 && pending == 0)
			$display("tb_pattern_span_fill_8bpp_top OK");
		else
			$display("tb_pattern_span_fill_8bpp_top NOT OK");
		$finish;
	end

endmodule
